[sv/ikc_pkg.sv]
package ikc_pkg;

  localparam int CordicIters = 16;
  localparam int AtanLen = 24;
  localparam int CordicSteps = (CordicIters < AtanLen) ? CordicIters : AtanLen;

  localparam logic [24:0] Deg90Q16 = 25'd5898240;
  localparam logic [24:0] Deg180Q16 = 25'd11796480;
  localparam logic signed [16:0] Deg150Q6 = 17'sd9600;
  localparam logic signed [16:0] AngleLimit = 17'sd23040;
  localparam logic [14:0] LinkReset = 15'd693;

  typedef struct packed {
    logic signed [15:0] target_x;
    logic signed [15:0] target_y;
  } ikc_in_t;

  typedef struct packed {
    logic signed [15:0] shoulder_angle;
    logic signed [15:0] elbow_angle;
    logic               reachable;
  } ikc_out_t;

  typedef enum logic [1:0] {MUL_XX, MUL_YY, MUL_LL, MUL_SR} ikc_mul_e;
  typedef enum logic [1:0] {CSEL_T1, CSEL_T2, CSEL_T3} ikc_csel_e;

  typedef enum logic [1:0] {CR_IDLE, CR_NORM, CR_ITER, CR_DONE} ikc_cr_state_e;

  typedef enum logic [3:0] {
    C_IDLE, C_SQX, C_SQY, C_SQL, C_CHECK, C_MUL, C_SQRT_GO, C_SQRT,
    C_CORD1, C_WAIT1, C_CORD2, C_WAIT2, C_CORD3, C_WAIT3, C_OUT
  } ikc_state_e;

  typedef struct packed {
    logic      load_in;
    logic      mul_en;
    ikc_mul_e  mul_sel;
    logic      check;
    logic      sqrt_start;
    logic      cord_start;
    ikc_csel_e cord_sel;
    logic      write_out;
  } ikc_cmd_t;

  typedef struct packed {
    logic reach;
    logic sqrt_done;
    logic cord_done;
    logic out_free;
  } ikc_sts_t;

  // arctan(2^-i) in degrees, scaled by 2^16
  function automatic logic [21:0] atan_deg(input logic [4:0] idx);
    logic [21:0] v;
    case (idx)
      5'd0: v = 22'd2949120;
      5'd1: v = 22'd1740967;
      5'd2: v = 22'd919879;
      5'd3: v = 22'd466945;
      5'd4: v = 22'd234379;
      5'd5: v = 22'd117306;
      5'd6: v = 22'd58666;
      5'd7: v = 22'd29335;
      5'd8: v = 22'd14668;
      5'd9: v = 22'd7334;
      5'd10: v = 22'd3667;
      5'd11: v = 22'd1833;
      5'd12: v = 22'd917;
      5'd13: v = 22'd458;
      5'd14: v = 22'd229;
      5'd15: v = 22'd115;
      5'd16: v = 22'd57;
      5'd17: v = 22'd29;
      5'd18: v = 22'd14;
      5'd19: v = 22'd7;
      5'd20: v = 22'd4;
      5'd21: v = 22'd2;
      5'd22: v = 22'd1;
      default: v = 22'd0;
    endcase
    return v;
  endfunction

endpackage

[sv/two_link_arm_inverse_kinematics_core.sv]
// Two-link planar arm inverse kinematics. Each input transfer carries a
// target point (signed Q8.8); each output transfer carries the shoulder and
// elbow angles in degrees (signed Q10.6) and a reachable flag. Both links have
// the length held in the configuration register (unsigned Q7.8, reset 693);
// write it only while the block is idle. Reach is tested exactly as
// x^2 + y^2 <= 4 l^2. Out of reach, the shoulder repeats the last shoulder
// result and the elbow is that angle minus 150 degrees, saturated.
// Timing: one item at a time. A reachable target goes through three
// squarings on one shared multiplier, a product s*(r-s), three 32-step
// bit-serial square roots run side by side, then three passes through one
// shared CORDIC (a normalizing shift, 16 rotations and a done state each).
// A pass whose two operands are both zero skips the shift and the rotations.
// A target out of reach skips the square roots and the CORDIC passes.
// Either path also waits while the previous result still sits untaken in the
// output register. The next input is taken once the result is in the output
// register, while that result waits to be taken.
module two_link_arm_inverse_kinematics_core import ikc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  ikc_in_t     in_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output ikc_out_t    out_data_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [14:0] cfg_data_i
);

  ikc_cmd_t cmd;
  ikc_sts_t sts;

  // configuration transfers are always taken
  assign cfg_ready_o = 1'b1;

  ikc_ctrl u_ctrl (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .sts_i(sts),
    .cmd_o(cmd)
  );

  ikc_datapath u_dp (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .cmd_i(cmd),
    .sts_o(sts),
    .in_data_i(in_data_i),
    .cfg_valid_i(cfg_valid_i),
    .cfg_data_i(cfg_data_i),
    .out_ready_i(out_ready_i),
    .out_valid_o(out_valid_o),
    .out_data_o(out_data_o)
  );

endmodule

[sv/ikc_isqrt.sv]
module ikc_isqrt import ikc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] val_i,
  output logic        done_o,
  output logic [31:0] root_o
);

  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [4:0]  cnt_q, cnt_d;
  logic [63:0] v_q, v_d;
  logic [33:0] rem_q, rem_d;
  logic [31:0] root_q, root_d;
  logic [34:0] rem2, trial;

  // one result bit per cycle: bring down two bits, try subtracting 4*root+1
  always_comb begin
    rem2 = {rem_q[32:0], v_q[63:62]};
    trial = {1'b0, root_q, 2'b01};
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d = cnt_q;
    v_d = v_q;
    rem_d = rem_q;
    root_d = root_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d = '0;
      v_d = val_i;
      rem_d = '0;
      root_d = '0;
    end else if (busy_q) begin
      v_d = {v_q[61:0], 2'b00};
      if (rem2 >= trial) begin
        rem_d = 34'(rem2 - trial);
        root_d = {root_q[30:0], 1'b1};
      end else begin
        rem_d = rem2[33:0];
        root_d = {root_q[30:0], 1'b0};
      end
      cnt_d = 5'(cnt_q + 5'd1);
      if (cnt_q == 5'd31) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    v_q <= v_d;
    rem_q <= rem_d;
    root_q <= root_d;
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

[sv/ikc_cordic.sv]
module ikc_cordic import ikc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [33:0] xs_i,
  input  logic [31:0]        ys_i,
  output logic               done_o,
  output logic [24:0]        angle_o
);

  ikc_cr_state_e     state_q, state_d;
  logic [4:0]        i_q;
  logic              neg_q;
  logic signed [43:0] vx_q, vy_q;
  logic signed [25:0] z_q;
  logic [33:0]       ax;
  logic [40:0]       vor;
  logic signed [43:0] dx, dy;
  logic signed [25:0] za, zc;

  assign ax = xs_i[33] ? 34'(-xs_i) : 34'(xs_i);
  assign vor = vx_q[40:0] | vy_q[40:0];
  assign dx = vy_q >>> i_q;
  assign dy = vx_q >>> i_q;
  assign za = 26'(atan_deg(i_q));

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      CR_IDLE: begin
        if (start_i) begin
          state_d = (ax == '0 && ys_i == '0) ? CR_DONE : CR_NORM;
        end
      end
      CR_NORM: begin
        if (vor[40]) state_d = CR_ITER;
      end
      CR_ITER: begin
        if (i_q == 5'(CordicSteps - 1)) state_d = CR_DONE;
      end
      CR_DONE: state_d = CR_IDLE;
      default: state_d = CR_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CR_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == CR_IDLE && start_i) begin
      neg_q <= xs_i[33];
      vx_q <= 44'(ax);
      vy_q <= 44'(ys_i);
      z_q <= '0;
      i_q <= '0;
    end else if (state_q == CR_NORM && !vor[40]) begin
      // coarse shift while far below the target magnitude
      if (vor[40:32] == '0) begin
        vx_q <= vx_q <<< 8;
        vy_q <= vy_q <<< 8;
      end else begin
        vx_q <= vx_q <<< 1;
        vy_q <= vy_q <<< 1;
      end
    end else if (state_q == CR_ITER) begin
      if (!vy_q[43]) begin
        vx_q <= vx_q + dx;
        vy_q <= vy_q - dy;
        z_q <= z_q + za;
      end else begin
        vx_q <= vx_q - dx;
        vy_q <= vy_q + dy;
        z_q <= z_q - za;
      end
      i_q <= 5'(i_q + 5'd1);
    end
  end

  always_comb begin
    if (z_q < 0) zc = '0;
    else if (z_q > $signed({1'b0, Deg90Q16})) zc = $signed({1'b0, Deg90Q16});
    else zc = z_q;
  end

  assign angle_o = neg_q ? 25'(Deg180Q16 - zc[24:0]) : zc[24:0];
  assign done_o = (state_q == CR_DONE);

endmodule

[sv/ikc_datapath.sv]
module ikc_datapath import ikc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  ikc_cmd_t    cmd_i,
  output ikc_sts_t    sts_o,
  input  ikc_in_t     in_data_i,
  input  logic        cfg_valid_i,
  input  logic [14:0] cfg_data_i,
  input  logic        out_ready_i,
  output logic        out_valid_o,
  output ikc_out_t    out_data_o
);

  logic [14:0]        link_q;
  logic signed [15:0] x_q;
  logic [15:0]        ax_q, ay_q;
  logic [31:0]        s_q;
  logic [29:0]        ll_q;
  logic [62:0]        prod_q;
  logic               reach_q;
  logic [24:0]        t1_q, t2_q, t3_q;
  logic signed [15:0] last_q;
  logic               out_valid_q;
  ikc_out_t           out_q;

  logic [31:0] mul_a, mul_b;
  logic [63:0] prod;
  logic [31:0] r_val, rs;
  logic signed [33:0] cos_e;
  logic [31:0] root_d, root_o, root_s;
  logic        done_d, done_o, done_s;
  logic signed [33:0] cord_xs;
  logic [31:0] cord_ys;
  logic        cord_done;
  logic [24:0] cord_angle;
  logic [25:0] sh_sum;
  logic [25:0] el_sum;
  logic signed [16:0] fb_elbow;
  ikc_out_t    res;

  assign r_val = {ll_q, 2'b00};
  assign rs = r_val - s_q;
  assign cos_e = $signed({3'b000, ll_q, 1'b0}) - $signed({2'b00, s_q});

  always_comb begin
    case (cmd_i.mul_sel)
      MUL_XX: begin
        mul_a = 32'(ax_q);
        mul_b = 32'(ax_q);
      end
      MUL_YY: begin
        mul_a = 32'(ay_q);
        mul_b = 32'(ay_q);
      end
      MUL_LL: begin
        mul_a = 32'(link_q);
        mul_b = 32'(link_q);
      end
      default: begin
        mul_a = s_q;
        mul_b = rs;
      end
    endcase
  end
  assign prod = mul_a * mul_b;

  ikc_isqrt u_sqrt_d (
    .clk_i(clk_i), .rst_ni(rst_ni), .start_i(cmd_i.sqrt_start),
    .val_i({32'd0, s_q}), .done_o(done_d), .root_o(root_d)
  );
  ikc_isqrt u_sqrt_o (
    .clk_i(clk_i), .rst_ni(rst_ni), .start_i(cmd_i.sqrt_start),
    .val_i({32'd0, rs}), .done_o(done_o), .root_o(root_o)
  );
  ikc_isqrt u_sqrt_s (
    .clk_i(clk_i), .rst_ni(rst_ni), .start_i(cmd_i.sqrt_start),
    .val_i({1'b0, prod_q}), .done_o(done_s), .root_o(root_s)
  );

  always_comb begin
    case (cmd_i.cord_sel)
      CSEL_T1: begin
        cord_xs = 34'(x_q);
        cord_ys = 32'(ay_q);
      end
      CSEL_T2: begin
        cord_xs = $signed({2'b00, root_d});
        cord_ys = root_o;
      end
      default: begin
        cord_xs = cos_e;
        cord_ys = root_s;
      end
    endcase
  end

  ikc_cordic u_cordic (
    .clk_i(clk_i), .rst_ni(rst_ni), .start_i(cmd_i.cord_start),
    .xs_i(cord_xs), .ys_i(cord_ys), .done_o(cord_done), .angle_o(cord_angle)
  );

  // round to Q10.6 and assemble the result
  assign sh_sum = 26'(t1_q) + 26'(t2_q) + 26'd512;
  assign el_sum = 26'(Deg180Q16 - t3_q) + 26'd512;
  assign fb_elbow = 17'(last_q) - Deg150Q6;

  always_comb begin
    if (reach_q) begin
      res.shoulder_angle = $signed(sh_sum[25:10]);
      res.elbow_angle = $signed(el_sum[25:10]);
      res.reachable = 1'b1;
    end else begin
      res.shoulder_angle = last_q;
      res.elbow_angle = (fb_elbow < -AngleLimit) ? 16'(-AngleLimit) : fb_elbow[15:0];
      res.reachable = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      link_q <= LinkReset;
      last_q <= '0;
      out_valid_q <= 1'b0;
      reach_q <= 1'b0;
    end else begin
      if (cfg_valid_i) link_q <= cfg_data_i;
      if (cmd_i.check) reach_q <= (s_q <= r_val);
      if (cmd_i.write_out) begin
        out_valid_q <= 1'b1;
        last_q <= res.shoulder_angle;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      x_q <= in_data_i.target_x;
      ax_q <= in_data_i.target_x[15] ? 16'(-in_data_i.target_x) : in_data_i.target_x;
      ay_q <= in_data_i.target_y[15] ? 16'(-in_data_i.target_y) : in_data_i.target_y;
    end
    if (cmd_i.mul_en) begin
      case (cmd_i.mul_sel)
        MUL_XX: s_q <= prod[31:0];
        MUL_YY: s_q <= s_q + prod[31:0];
        MUL_LL: ll_q <= prod[29:0];
        default: prod_q <= prod[62:0];
      endcase
    end
    if (cord_done) begin
      case (cmd_i.cord_sel)
        CSEL_T1: t1_q <= cord_angle;
        CSEL_T2: t2_q <= cord_angle;
        default: t3_q <= cord_angle;
      endcase
    end
    if (cmd_i.write_out) out_q <= res;
  end

  assign sts_o.reach = reach_q;
  assign sts_o.sqrt_done = done_d & done_o & done_s;
  assign sts_o.cord_done = cord_done;
  assign sts_o.out_free = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o = out_q;

endmodule

[sv/ikc_ctrl.sv]
module ikc_ctrl import ikc_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  ikc_sts_t sts_i,
  output ikc_cmd_t cmd_o
);

  ikc_state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      C_IDLE:    if (in_valid_i) state_d = C_SQX;
      C_SQX:     state_d = C_SQY;
      C_SQY:     state_d = C_SQL;
      C_SQL:     state_d = C_CHECK;
      C_CHECK:   state_d = C_MUL;
      C_MUL:     state_d = sts_i.reach ? C_SQRT_GO : C_OUT;
      C_SQRT_GO: state_d = C_SQRT;
      C_SQRT:    if (sts_i.sqrt_done) state_d = C_CORD1;
      C_CORD1:   state_d = C_WAIT1;
      C_WAIT1:   if (sts_i.cord_done) state_d = C_CORD2;
      C_CORD2:   state_d = C_WAIT2;
      C_WAIT2:   if (sts_i.cord_done) state_d = C_CORD3;
      C_CORD3:   state_d = C_WAIT3;
      C_WAIT3:   if (sts_i.cord_done) state_d = C_OUT;
      C_OUT:     if (sts_i.out_free) state_d = C_IDLE;
      default:   state_d = C_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    cmd_o.mul_sel = MUL_SR;
    cmd_o.cord_sel = CSEL_T1;
    in_ready_o = 1'b0;
    unique case (state_q)
      C_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load_in = in_valid_i;
      end
      C_SQX: begin
        cmd_o.mul_en = 1'b1;
        cmd_o.mul_sel = MUL_XX;
      end
      C_SQY: begin
        cmd_o.mul_en = 1'b1;
        cmd_o.mul_sel = MUL_YY;
      end
      C_SQL: begin
        cmd_o.mul_en = 1'b1;
        cmd_o.mul_sel = MUL_LL;
      end
      C_CHECK: cmd_o.check = 1'b1;
      C_MUL: cmd_o.mul_en = 1'b1;
      C_SQRT_GO: cmd_o.sqrt_start = 1'b1;
      C_CORD1: begin
        cmd_o.cord_start = 1'b1;
        cmd_o.cord_sel = CSEL_T1;
      end
      C_WAIT1: cmd_o.cord_sel = CSEL_T1;
      C_CORD2: begin
        cmd_o.cord_start = 1'b1;
        cmd_o.cord_sel = CSEL_T2;
      end
      C_WAIT2: cmd_o.cord_sel = CSEL_T2;
      C_CORD3: begin
        cmd_o.cord_start = 1'b1;
        cmd_o.cord_sel = CSEL_T3;
      end
      C_WAIT3: cmd_o.cord_sel = CSEL_T3;
      C_OUT: cmd_o.write_out = sts_i.out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= C_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

[tb/two_link_arm_inverse_kinematics_core_tb.sv]
module two_link_arm_inverse_kinematics_core_tb;
  import ikc_pkg::*;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  ikc_in_t     in_data_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  ikc_out_t    out_data_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [14:0] cfg_data_i = '0;

  two_link_arm_inverse_kinematics_core u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // Predictor state: a private copy of the link length and the last shoulder.
  logic [14:0]        pred_link;
  logic signed [15:0] pred_last_shoulder;
  ikc_out_t           angle_queue[$];

  int unsigned send_idle_pct = 0;  // chance per cycle that the sender holds off
  int unsigned recv_stall_pct = 0; // chance per cycle that the receiver stalls
  int unsigned hold_off_cycles = 0;
  int          mismatch_count = 0;
  int          result_count = 0;

  // Integer square root, floor.
  function automatic logic [63:0] floor_sqrt(input logic [63:0] v);
    logic [63:0] res;
    logic [63:0] bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic longint unsigned arctan_step(input int k);
    longint unsigned t[24] = '{2949120, 1740967, 919879, 466945, 234379, 117306,
                               58666, 29335, 14668, 7334, 3667, 1833, 917, 458,
                               229, 115, 57, 29, 14, 7, 4, 2, 1, 0};
    return t[k];
  endfunction

  // Vectoring CORDIC: angle of (xs, ys) in degrees scaled by 2^16, ys >= 0.
  function automatic longint vector_angle(input longint xs, input longint unsigned ys);
    logic            neg;
    longint unsigned ax;
    longint          x, y, z, dx, dy;
    neg = xs < 0;
    ax = neg ? -xs : xs;
    z = 0;
    if (ax == 0 && ys == 0) return 0;
    while ((ax | ys) < (64'd1 << 40)) begin
      ax <<= 1;
      ys <<= 1;
    end
    x = ax;
    y = ys;
    for (int i = 0; i < 16; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x += dx; y -= dy; z += arctan_step(i);
      end else begin
        x -= dx; y += dy; z -= arctan_step(i);
      end
    end
    if (z < 0) z = 0;
    if (z > 5898240) z = 5898240;
    return neg ? 11796480 - z : z;
  endfunction

  function automatic logic signed [15:0] deg_to_q6(input longint d);
    return 16'((d + 512) >>> 10);
  endfunction

  // Work out the joint angles for one target and advance the predictor state.
  function automatic ikc_out_t solve_joints(input ikc_in_t t);
    ikc_out_t        o;
    longint          x, y, ce, t1, t2, t3, el;
    longint unsigned ay, s, r, l;
    x = t.target_x;
    y = t.target_y;
    ay = (y < 0) ? -y : y;
    l = pred_link;
    s = x * x + ay * ay;
    r = 4 * l * l;
    if (s <= r) begin
      ce = 2 * l * l - s;
      t1 = vector_angle(x, ay);
      t2 = vector_angle(floor_sqrt(s), floor_sqrt(r - s));
      t3 = vector_angle(ce, floor_sqrt(s * (r - s)));
      o.shoulder_angle = deg_to_q6(t1 + t2);
      o.elbow_angle = deg_to_q6(11796480 - t3);
      o.reachable = 1'b1;
    end else begin
      el = longint'(pred_last_shoulder) - 9600;
      if (el < -23040) el = -23040;
      if (el > 23040) el = 23040;
      o.shoulder_angle = pred_last_shoulder;
      o.elbow_angle = 16'(el);
      o.reachable = 1'b0;
    end
    pred_last_shoulder = o.shoulder_angle;
    return o;
  endfunction

  // Send one target: wait out random idle cycles, then hold valid to the transfer.
  task automatic send_target(input logic signed [15:0] tx, input logic signed [15:0] ty);
    ikc_in_t t;
    t.target_x = tx;
    t.target_y = ty;
    while ($urandom_range(99) < send_idle_pct) @(negedge clk_i);
    in_valid_i = 1'b1;
    in_data_i = t;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    angle_queue.push_back(solve_joints(t));
    @(negedge clk_i);
    in_valid_i = 1'b0;
  endtask

  // Drain every expected result, then let the block settle before a config write.
  task automatic wait_idle();
    while (angle_queue.size() != 0) @(negedge clk_i);
    repeat (130) @(negedge clk_i);
  endtask

  task automatic write_link(input logic [14:0] len);
    wait_idle();
    cfg_valid_i <= 1'b1;
    cfg_data_i <= len;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    pred_link = len;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Pick a point: mostly in the square that bounds the reach, sometimes out, sometimes anywhere.
  task automatic send_random_target();
    int          kind;
    longint      reach;
    logic signed [15:0] tx, ty;
    kind = $urandom_range(9);
    reach = 2 * longint'(pred_link);
    if (kind < 6 && reach > 0) begin
      tx = 16'($signed($urandom_range(2 * ((reach > 23000) ? 23000 : reach))) -
               ((reach > 23000) ? 23000 : reach));
      ty = 16'($signed($urandom_range(2 * ((reach > 23000) ? 23000 : reach))) -
               ((reach > 23000) ? 23000 : reach));
    end else if (kind < 8) begin
      tx = 16'(reach + $urandom_range(200));
      ty = 16'($urandom());
    end else begin
      tx = 16'($urandom());
      ty = 16'($urandom());
    end
    send_target(tx, ty);
  endtask

  task automatic test_directed();
    send_target(16'sd0, 16'sd0);
    send_target(16'sd300, 16'sd200);
    send_target(16'sd32767, 16'sd32767);
    send_target(-16'sd32768, -16'sd32768);
    send_target(-16'sd500, 16'sd100);
    send_target(16'sd1386, 16'sd0);
    send_target(16'sd1387, 16'sd0);
    send_target(16'sd0, -16'sd1386);
    send_target(-16'sd1386, 16'sd0);
    send_target(16'sd1, -16'sd1);
    send_target(-16'sd1, 16'sd1);
    send_target(-16'sd300, -16'sd900);
    send_target(-16'sd30000, 16'sd5);
    send_target(16'sd5, -16'sd30000);
    // Feed the fallback elbow from a reachable shoulder; shoulders are never
    // negative, so the elbow stays above its lower limit.
    send_target(-16'sd10, -16'sd1380);
    send_target(16'sd20000, 16'sd20000);
  endtask

  task automatic test_link_extremes();
    write_link(15'd0);
    send_target(16'sd0, 16'sd0);
    send_target(16'sd1, 16'sd0);
    write_link(15'd32767);
    send_target(16'sd32767, -16'sd32768);
    send_target(-16'sd32768, 16'sd32767);
    send_target(16'sd0, 16'sd0);
    send_target(16'sd12345, -16'sd23456);
    write_link(15'd1);
    send_target(16'sd2, 16'sd0);
    send_target(16'sd1, 16'sd1);
    send_target(16'sd3, 16'sd0);
  endtask

  task automatic test_random_phase(input int n, input int unsigned idle,
                                   input int unsigned stall);
    send_idle_pct = idle;
    recv_stall_pct = stall;
    repeat (n) send_random_target();
  endtask

  // Hold off the receiver long enough for the block to fill and stall its input.
  task automatic test_back_pressure();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_off_cycles = 600;
    repeat (6) send_random_target();
    wait (hold_off_cycles == 0);
    while (angle_queue.size() != 0) @(negedge clk_i);
    repeat (4) send_random_target();
  endtask

  // Receiver: random stalls plus an occasional long hold-off.
  always @(negedge clk_i) begin
    if (hold_off_cycles != 0) begin
      hold_off_cycles <= hold_off_cycles - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Check each result transfer against the oldest expectation.
  always @(posedge clk_i) begin
    ikc_out_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      result_count++;
      if (angle_queue.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) $display("unexpected result %p", out_data_o);
      end else begin
        want = angle_queue.pop_front();
        if (want.shoulder_angle !== out_data_o.shoulder_angle ||
            want.elbow_angle !== out_data_o.elbow_angle ||
            want.reachable !== out_data_o.reachable) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("mismatch #%0d: expected %p, got %p", result_count, want, out_data_o);
        end
      end
    end
  end

  initial begin
    pred_link = LinkReset;
    pred_last_shoulder = '0;
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_directed();
    test_link_extremes();
    write_link(15'd693);
    test_random_phase(400, 0, 0);
    write_link(15'd4000);
    test_random_phase(400, 82, 0);
    write_link(15'd37);
    test_random_phase(400, 0, 82);
    write_link(15'd16000);
    test_random_phase(400, 8, 8);
    test_back_pressure();
    write_link(15'd200);
    test_random_phase(150, 0, 0);
    wait_idle();
    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
